// ===== rtl/core/hsvk_pkg.sv =====
// Shared constants, codes and stage payload types for the HSV pixel key.
`default_nettype none
package hsvk_pkg;

    localparam int COLOR_BITS = 8;
    localparam int HUE_W      = 9;
    localparam int SATC_W     = 7;
    localparam int HSUB_W     = COLOR_BITS + 3;
    localparam int PROD_W     = COLOR_BITS + 9;
    localparam int SAT_W      = COLOR_BITS + 7;

    localparam int HUE_SCALE = 60;
    localparam int SAT_SCALE = 100;

    localparam logic [HUE_W-1:0]  HUE_LOW_RESET  = HUE_W'(25);
    localparam logic [HUE_W-1:0]  HUE_HIGH_RESET = HUE_W'(60);
    localparam logic [SATC_W-1:0] SAT_MIN_RESET  = SATC_W'(60);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_MIN  = 2'd2;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] mx;
        logic [COLOR_BITS-1:0] mn;
        logic [1:0]            sector;
    } t_ext;

    typedef struct packed {
        logic [HSUB_W-1:0]     hsub;
        logic [COLOR_BITS-1:0] delta;
        logic [COLOR_BITS-1:0] mx;
        logic                  chroma;
    } t_hue;

    typedef struct packed {
        logic [PROD_W-1:0] hnum;
        logic [PROD_W-1:0] lo_bound;
        logic [PROD_W-1:0] hi_bound;
        logic [SAT_W-1:0]  sat_lhs;
        logic [SAT_W-1:0]  sat_rhs;
        logic              chroma;
    } t_prod;

endpackage
`default_nettype wire

// ===== rtl/core/hsvk_extrema.sv =====
// First stage: maximum, minimum and dominant sector of the pixel.
`default_nettype none
module hsvk_extrema (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0] i_red,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0] i_green,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0] i_blue,
    output      logic                            o_valid,
    output      hsvk_pkg::t_ext                  o_data
);

    logic           r_valid;
    hsvk_pkg::t_ext r_data;
    hsvk_pkg::t_ext n_data;

    always_comb begin
        n_data.red   = i_red;
        n_data.green = i_green;
        n_data.blue  = i_blue;
        n_data.mx    = (i_red > i_green) ? i_red : i_green;
        n_data.mn    = (i_red < i_green) ? i_red : i_green;
        if (i_blue > n_data.mx) begin
            n_data.mx = i_blue;
        end
        if (i_blue < n_data.mn) begin
            n_data.mn = i_blue;
        end
        // Ties go to red first, then green, as the hue definition requires.
        if (i_red >= i_green && i_red >= i_blue) begin
            n_data.sector = hsvk_pkg::SEC_RED;
        end else if (i_green >= i_blue) begin
            n_data.sector = hsvk_pkg::SEC_GREEN;
        end else begin
            n_data.sector = hsvk_pkg::SEC_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/hsvk_sector.sv =====
// Second stage: chroma and the hue numerator in sixths of a turn.
`default_nettype none
module hsvk_sector (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire hsvk_pkg::t_ext i_data,
    output      logic           o_valid,
    output      hsvk_pkg::t_hue o_data
);

    logic                            r_valid;
    hsvk_pkg::t_hue                  r_data;
    hsvk_pkg::t_hue                  n_data;
    logic [hsvk_pkg::COLOR_BITS-1:0] delta;
    logic [hsvk_pkg::HSUB_W-1:0]     d_w;
    logic [hsvk_pkg::HSUB_W-1:0]     r_w;
    logic [hsvk_pkg::HSUB_W-1:0]     g_w;
    logic [hsvk_pkg::HSUB_W-1:0]     b_w;

    always_comb begin
        delta = i_data.mx - i_data.mn;
        d_w   = hsvk_pkg::HSUB_W'(delta);
        r_w   = hsvk_pkg::HSUB_W'(i_data.red);
        g_w   = hsvk_pkg::HSUB_W'(i_data.green);
        b_w   = hsvk_pkg::HSUB_W'(i_data.blue);
        // Every sector result lies in [0, 6*delta), so modular arithmetic is exact.
        unique case (i_data.sector)
            hsvk_pkg::SEC_RED: begin
                n_data.hsub = g_w - b_w
                    + ((i_data.green < i_data.blue) ? ((d_w << 2) + (d_w << 1)) : '0);
            end
            hsvk_pkg::SEC_GREEN: begin
                n_data.hsub = (d_w << 1) + b_w - r_w;
            end
            default: begin
                n_data.hsub = (d_w << 2) + r_w - g_w;
            end
        endcase
        n_data.delta  = delta;
        n_data.mx     = i_data.mx;
        n_data.chroma = (delta != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/hsvk_scale.sv =====
// Third stage: constant and bound products for the cross-multiplied compares.
`default_nettype none
module hsvk_scale (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire hsvk_pkg::t_hue              i_data,
    input  wire logic [hsvk_pkg::HUE_W-1:0]  i_hue_low,
    input  wire logic [hsvk_pkg::HUE_W-1:0]  i_hue_high,
    input  wire logic [hsvk_pkg::SATC_W-1:0] i_sat_min,
    output      logic                        o_valid,
    output      hsvk_pkg::t_prod             o_data
);

    logic            r_valid;
    hsvk_pkg::t_prod r_data;
    hsvk_pkg::t_prod n_data;

    always_comb begin
        n_data.hnum     = hsvk_pkg::PROD_W'(i_data.hsub)
                        * hsvk_pkg::PROD_W'(hsvk_pkg::HUE_SCALE);
        n_data.lo_bound = hsvk_pkg::PROD_W'(i_hue_low)  * hsvk_pkg::PROD_W'(i_data.delta);
        n_data.hi_bound = hsvk_pkg::PROD_W'(i_hue_high) * hsvk_pkg::PROD_W'(i_data.delta);
        n_data.sat_lhs  = hsvk_pkg::SAT_W'(i_data.delta)
                        * hsvk_pkg::SAT_W'(hsvk_pkg::SAT_SCALE);
        n_data.sat_rhs  = hsvk_pkg::SAT_W'(i_sat_min) * hsvk_pkg::SAT_W'(i_data.mx);
        n_data.chroma   = i_data.chroma;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// ===== rtl/core/hsvk_compare.sv =====
// Fourth stage: hue window and saturation compares into the output register.
`default_nettype none
module hsvk_compare (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire hsvk_pkg::t_prod i_data,
    output      logic            o_valid,
    output      logic            o_in_range
);

    logic r_valid;
    logic r_in_range;
    logic n_in_range;

    assign n_in_range = i_data.chroma
                     && (i_data.hnum >= i_data.lo_bound)
                     && (i_data.hnum <= i_data.hi_bound)
                     && (i_data.sat_lhs >= i_data.sat_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_range <= n_in_range;
        end
    end

    assign o_valid    = r_valid;
    assign o_in_range = r_in_range;

endmodule
`default_nettype wire

// ===== rtl/core/hsv_hue_saturation_pixel_key.sv =====
// Throughput: one pixel per clock while key beats are taken; each stage holds when its
// successor is full and stalled, so bubbles are squeezed out and a stall loses or
// repeats nothing. One register per stage sets the rate; intake stalls only when all
// four stages are full and the output beat is not taken.
// Reset (synchronous, active low) empties every stage and loads the default bounds:
// hue 25 to 60 degrees and saturation of at least 60 percent.
`default_nettype none
module hsv_hue_saturation_pixel_key (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [hsvk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hsvk_pkg::HUE_W-1:0]       i_cfg_wr_data,
    // Pixel input channel.
    input  wire logic                             i_pix_valid,
    output      logic                             o_pix_ready,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0]  i_red,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0]  i_green,
    input  wire logic [hsvk_pkg::COLOR_BITS-1:0]  i_blue,
    // Key output channel.
    output      logic                             o_key_valid,
    input  wire logic                             i_key_ready,
    output      logic                             o_in_range
);

    logic [hsvk_pkg::HUE_W-1:0]  r_hue_low;
    logic [hsvk_pkg::HUE_W-1:0]  r_hue_high;
    logic [hsvk_pkg::SATC_W-1:0] r_sat_min;

    logic            s1_valid;
    logic            s2_valid;
    logic            s3_valid;
    hsvk_pkg::t_ext  s1_data;
    hsvk_pkg::t_hue  s2_data;
    hsvk_pkg::t_prod s3_data;

    logic en1;
    logic en2;
    logic en3;
    logic en4;

    // Configuration registers, read live by the stages with no shadow copy. Writes must come
    // only while the pipeline is empty; nothing here enforces it. An unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= hsvk_pkg::HUE_LOW_RESET;
            r_hue_high <= hsvk_pkg::HUE_HIGH_RESET;
            r_sat_min  <= hsvk_pkg::SAT_MIN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                hsvk_pkg::CFG_HUE_LOW:  r_hue_low  <= i_cfg_wr_data;
                hsvk_pkg::CFG_HUE_HIGH: r_hue_high <= i_cfg_wr_data;
                hsvk_pkg::CFG_SAT_MIN:  r_sat_min  <= i_cfg_wr_data[hsvk_pkg::SATC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves on. The output
    // stage moves on when its beat is taken, so a waiting result never blocks intake
    // while any earlier stage still has room.
    assign en4 = !o_key_valid || i_key_ready;
    assign en3 = !s3_valid || en4;
    assign en2 = !s2_valid || en3;
    assign en1 = !s1_valid || en2;

    assign o_pix_ready = en1;

    hsvk_extrema u_extrema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en1),
        .i_valid (i_pix_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    hsvk_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    hsvk_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en3),
        .i_valid    (s2_valid),
        .i_data     (s2_data),
        .i_hue_low  (r_hue_low),
        .i_hue_high (r_hue_high),
        .i_sat_min  (r_sat_min),
        .o_valid    (s3_valid),
        .o_data     (s3_data)
    );

    // The final stage doubles as the output register of the key channel.
    hsvk_compare u_compare (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en4),
        .i_valid    (s3_valid),
        .i_data     (s3_data),
        .o_valid    (o_key_valid),
        .o_in_range (o_in_range)
    );

endmodule
`default_nettype wire
